[design/mcfe_pkg.sv]
package mcfe_pkg;

   localparam int LANES     = 5;
   localparam int DIV_STEPS = 16;
   localparam int STAGES    = DIV_STEPS + 3;
   localparam int DATA_W    = 32;
   localparam int DIFF_W    = 34;
   localparam int SPAN_W    = 32;
   localparam int DSR_W     = SPAN_W + 1;
   localparam int DVD_W     = DSR_W + DIV_STEPS;
   localparam int CODE_W    = DIV_STEPS;
   localparam int POS_BITS  = 16;
   localparam int GAIN_BITS = 12;
   localparam int LIMIT_W   = 31;
   localparam int FRAME_W   = 64;
   localparam int CSR_IDX_W = 3;

   localparam int LANE_POSITION  = 0;
   localparam int LANE_VELOCITY  = 1;
   localparam int LANE_STIFFNESS = 2;
   localparam int LANE_DAMPING   = 3;
   localparam int LANE_TORQUE    = 4;

   localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST = 31'd819200;
   localparam logic [LIMIT_W-1:0] VELOCITY_BOUND_RST = 31'd1966080;
   localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST   = 31'd655360;
   localparam logic [DATA_W-1:0]  STIFFNESS_MIN_RST  = 32'd0;
   localparam logic [DATA_W-1:0]  STIFFNESS_MAX_RST  = 32'd32768000;
   localparam logic [DATA_W-1:0]  DAMPING_MIN_RST    = 32'd0;
   localparam logic [DATA_W-1:0]  DAMPING_MAX_RST    = 32'd327680;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSITION_LIMIT = 3'd0,
      CSR_VELOCITY_BOUND = 3'd1,
      CSR_TORQUE_LIMIT   = 3'd2,
      CSR_STIFFNESS_MIN  = 3'd3,
      CSR_STIFFNESS_MAX  = 3'd4,
      CSR_DAMPING_MIN    = 3'd5,
      CSR_DAMPING_MAX    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic zero;
      logic full;
   } range_flag_type;

   function automatic int code_bits(input int lane);
      return (lane == LANE_POSITION) ? POS_BITS : GAIN_BITS;
   endfunction

endpackage

[design/mit_command_frame_encoder_top.sv]
// Packs one motor command (position, velocity, stiffness, damping, torque, all
// signed Q16.16) into an 8-byte frame of range-mapped codes. One command is
// accepted per clock while req_tready is high. A request passes a range offset
// stage, a dividend stage, 16 restoring divider stages (one quotient bit per
// stage, five lanes side by side) and an output register. Each stage holds only
// while the stage after it is full and stalled, so the pipeline keeps taking
// requests while a finished frame waits, until all 19 stages are full. Limit and
// range registers are read at the first stage; the user must write them only
// while no request is in flight, and the block itself does not enforce this.
module mit_command_frame_encoder_top (
   input  logic         clock,
   input  logic         reset,
   // target_position, target_velocity, stiffness_gain, damping_gain,
   // feedforward_torque, 32 bits each from bit 0 up
   input  logic [159:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_byte_0 .. frame_byte_7, 8 bits each from bit 0 up
   output logic [63:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int LN = mcfe_pkg::LANES;
   localparam int NS = mcfe_pkg::STAGES;
   localparam int DS = mcfe_pkg::DIV_STEPS;

   // configuration
   logic [mcfe_pkg::LIMIT_W-1:0] pos_lim_ff, vel_lim_ff, tq_lim_ff;
   logic [mcfe_pkg::DATA_W-1:0]  kp_min_ff, kp_max_ff, kd_min_ff, kd_max_ff;

   // pipeline control
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] adv;

   // range front end
   logic signed [mcfe_pkg::DIFF_W-1:0] lo_sel  [LN];
   logic signed [mcfe_pkg::DIFF_W-1:0] hi_sel  [LN];
   logic signed [mcfe_pkg::DIFF_W-1:0] value   [LN];
   logic signed [mcfe_pkg::DIFF_W-1:0] num_dif [LN];
   logic signed [mcfe_pkg::DIFF_W-1:0] spn_dif [LN];
   logic [mcfe_pkg::SPAN_W-1:0] num_ff  [LN];
   logic [mcfe_pkg::SPAN_W-1:0] num_in  [LN];
   logic [mcfe_pkg::SPAN_W-1:0] span_ff [LN];
   logic [mcfe_pkg::SPAN_W-1:0] span_in [LN];
   mcfe_pkg::range_flag_type    flg0_ff [LN];
   mcfe_pkg::range_flag_type    flg0_in [LN];

   // dividend stage
   logic [49:0] prod [LN];
   logic [49:0] dd   [LN];
   logic [49:0] dds  [LN];
   logic [mcfe_pkg::DVD_W-1:0] dvd_ff  [LN];
   logic [mcfe_pkg::DVD_W-1:0] dvd_in  [LN];
   logic [mcfe_pkg::DSR_W-1:0] dsr1_ff [LN];
   logic [mcfe_pkg::DSR_W-1:0] dsr1_in [LN];
   mcfe_pkg::range_flag_type   flg1_ff [LN];

   // divider stages
   logic [mcfe_pkg::DSR_W-1:0]  rem_ff [DS][LN];
   logic [mcfe_pkg::DSR_W-1:0]  rem_in [DS][LN];
   logic [mcfe_pkg::CODE_W-1:0] acc_ff [DS][LN];
   logic [mcfe_pkg::CODE_W-1:0] acc_in [DS][LN];
   logic [mcfe_pkg::DSR_W-1:0]  dsr_ff [DS][LN];
   logic [mcfe_pkg::DSR_W-1:0]  dsr_in [DS][LN];
   mcfe_pkg::range_flag_type    flg_ff [DS][LN];
   mcfe_pkg::range_flag_type    flg_in [DS][LN];
   logic [mcfe_pkg::DSR_W-1:0]  rem_src [DS][LN];
   logic [mcfe_pkg::CODE_W-1:0] acc_src [DS][LN];
   logic [mcfe_pkg::DSR_W+1:0]  trial   [DS][LN];

   // output
   logic [mcfe_pkg::CODE_W-1:0]  code [LN];
   logic [mcfe_pkg::FRAME_W-1:0] rsp_data_ff;
   logic [mcfe_pkg::FRAME_W-1:0] rsp_data_in;

   assign csr_ready  = 1'b1;
   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = rsp_data_ff;

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = req_tvalid;
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   // offsets into the range and range flags
   always_comb begin
      hi_sel[mcfe_pkg::LANE_POSITION]  = $signed({3'b000, pos_lim_ff});
      lo_sel[mcfe_pkg::LANE_POSITION]  = -hi_sel[mcfe_pkg::LANE_POSITION];
      hi_sel[mcfe_pkg::LANE_VELOCITY]  = $signed({3'b000, vel_lim_ff});
      lo_sel[mcfe_pkg::LANE_VELOCITY]  = -hi_sel[mcfe_pkg::LANE_VELOCITY];
      hi_sel[mcfe_pkg::LANE_TORQUE]    = $signed({3'b000, tq_lim_ff});
      lo_sel[mcfe_pkg::LANE_TORQUE]    = -hi_sel[mcfe_pkg::LANE_TORQUE];
      hi_sel[mcfe_pkg::LANE_STIFFNESS] = $signed({{2{kp_max_ff[31]}}, kp_max_ff});
      lo_sel[mcfe_pkg::LANE_STIFFNESS] = $signed({{2{kp_min_ff[31]}}, kp_min_ff});
      hi_sel[mcfe_pkg::LANE_DAMPING]   = $signed({{2{kd_max_ff[31]}}, kd_max_ff});
      lo_sel[mcfe_pkg::LANE_DAMPING]   = $signed({{2{kd_min_ff[31]}}, kd_min_ff});
      for (int l = 0; l < LN; l++) begin
         value[l]   = $signed({{2{req_tdata[32*l+31]}}, req_tdata[32*l +: 32]});
         num_dif[l] = value[l] - lo_sel[l];
         spn_dif[l] = hi_sel[l] - lo_sel[l];
         num_in[l]  = num_dif[l][mcfe_pkg::SPAN_W-1:0];
         span_in[l] = spn_dif[l][mcfe_pkg::SPAN_W-1:0];
         flg0_in[l].zero = (spn_dif[l] <= 34'sd0) || (num_dif[l] <= 34'sd0);
         flg0_in[l].full = (num_dif[l] >= spn_dif[l]);
      end
   end

   // dividend = (2*num*full_scale + span), scaled up so every lane has 16 quotient bits
   always_comb begin
      for (int l = 0; l < LN; l++) begin
         prod[l]    = ({18'b0, num_ff[l]} << mcfe_pkg::code_bits(l)) - {18'b0, num_ff[l]};
         dd[l]      = (prod[l] << 1) + {18'b0, span_ff[l]};
         dds[l]     = dd[l] << (mcfe_pkg::CODE_W - mcfe_pkg::code_bits(l));
         dvd_in[l]  = dds[l][mcfe_pkg::DVD_W-1:0];
         dsr1_in[l] = {span_ff[l], 1'b0};
      end
   end

   // restoring divider, quotient bits shift into acc behind the dividend bits
   always_comb begin
      for (int k = 0; k < DS; k++) begin
         for (int l = 0; l < LN; l++) begin
            if (k == 0) begin
               rem_src[k][l] = dvd_ff[l][mcfe_pkg::DVD_W-1:mcfe_pkg::CODE_W];
               acc_src[k][l] = dvd_ff[l][mcfe_pkg::CODE_W-1:0];
               dsr_in[k][l]  = dsr1_ff[l];
               flg_in[k][l]  = flg1_ff[l];
            end else begin
               rem_src[k][l] = rem_ff[k-1][l];
               acc_src[k][l] = acc_ff[k-1][l];
               dsr_in[k][l]  = dsr_ff[k-1][l];
               flg_in[k][l]  = flg_ff[k-1][l];
            end
            trial[k][l] = {1'b0, rem_src[k][l], acc_src[k][l][mcfe_pkg::CODE_W-1]}
                          - {2'b00, dsr_in[k][l]};
            if (!trial[k][l][mcfe_pkg::DSR_W+1]) begin
               rem_in[k][l] = trial[k][l][mcfe_pkg::DSR_W-1:0];
               acc_in[k][l] = {acc_src[k][l][mcfe_pkg::CODE_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = {rem_src[k][l][mcfe_pkg::DSR_W-2:0],
                               acc_src[k][l][mcfe_pkg::CODE_W-1]};
               acc_in[k][l] = {acc_src[k][l][mcfe_pkg::CODE_W-2:0], 1'b0};
            end
         end
      end
   end

   // saturation and frame packing
   always_comb begin
      for (int l = 0; l < LN; l++) begin
         if (flg_ff[DS-1][l].zero) begin
            code[l] = '0;
         end else if (flg_ff[DS-1][l].full) begin
            code[l] = mcfe_pkg::CODE_W'((1 << mcfe_pkg::code_bits(l)) - 1);
         end else begin
            code[l] = acc_ff[DS-1][l] >> (mcfe_pkg::CODE_W - mcfe_pkg::code_bits(l));
         end
      end
      rsp_data_in[7:0]   = code[mcfe_pkg::LANE_POSITION][15:8];
      rsp_data_in[15:8]  = code[mcfe_pkg::LANE_POSITION][7:0];
      rsp_data_in[23:16] = code[mcfe_pkg::LANE_VELOCITY][11:4];
      rsp_data_in[31:24] = {code[mcfe_pkg::LANE_VELOCITY][3:0],
                            code[mcfe_pkg::LANE_STIFFNESS][11:8]};
      rsp_data_in[39:32] = code[mcfe_pkg::LANE_STIFFNESS][7:0];
      rsp_data_in[47:40] = code[mcfe_pkg::LANE_DAMPING][11:4];
      rsp_data_in[55:48] = {code[mcfe_pkg::LANE_DAMPING][3:0],
                            code[mcfe_pkg::LANE_TORQUE][11:8]};
      rsp_data_in[63:56] = code[mcfe_pkg::LANE_TORQUE][7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         pos_lim_ff <= mcfe_pkg::POSITION_LIMIT_RST;
         vel_lim_ff <= mcfe_pkg::VELOCITY_BOUND_RST;
         tq_lim_ff  <= mcfe_pkg::TORQUE_LIMIT_RST;
         kp_min_ff  <= mcfe_pkg::STIFFNESS_MIN_RST;
         kp_max_ff  <= mcfe_pkg::STIFFNESS_MAX_RST;
         kd_min_ff  <= mcfe_pkg::DAMPING_MIN_RST;
         kd_max_ff  <= mcfe_pkg::DAMPING_MAX_RST;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
         if (csr_valid) begin
            unique case (mcfe_pkg::csr_index_type'(csr_index))
               mcfe_pkg::CSR_POSITION_LIMIT: pos_lim_ff <= csr_data[mcfe_pkg::LIMIT_W-1:0];
               mcfe_pkg::CSR_VELOCITY_BOUND: vel_lim_ff <= csr_data[mcfe_pkg::LIMIT_W-1:0];
               mcfe_pkg::CSR_TORQUE_LIMIT:   tq_lim_ff  <= csr_data[mcfe_pkg::LIMIT_W-1:0];
               mcfe_pkg::CSR_STIFFNESS_MIN:  kp_min_ff  <= csr_data;
               mcfe_pkg::CSR_STIFFNESS_MAX:  kp_max_ff  <= csr_data;
               mcfe_pkg::CSR_DAMPING_MIN:    kd_min_ff  <= csr_data;
               mcfe_pkg::CSR_DAMPING_MAX:    kd_max_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         num_ff  <= num_in;
         span_ff <= span_in;
         flg0_ff <= flg0_in;
      end
      if (adv[1]) begin
         dvd_ff  <= dvd_in;
         dsr1_ff <= dsr1_in;
         flg1_ff <= flg0_ff;
      end
      for (int k = 0; k < DS; k++) begin
         if (adv[k+2]) begin
            rem_ff[k] <= rem_in[k];
            acc_ff[k] <= acc_in[k];
            dsr_ff[k] <= dsr_in[k];
            flg_ff[k] <= flg_in[k];
         end
      end
      if (adv[NS-1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_fills_front: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_stall_holds_front: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !adv[0] |=> vld_ff[0] && $stable(num_ff[0]))
      else $error("stalled front stage lost its request");

   a_mid_range_bounded: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !flg0_ff[0].zero && !flg0_ff[0].full |-> num_ff[0] < span_ff[0])
      else $error("position offset not below span in mid range");

   a_remainder_bounded: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-2] && !flg_ff[DS-1][0].zero && !flg_ff[DS-1][0].full
      |-> rem_ff[DS-1][0] < dsr_ff[DS-1][0])
      else $error("divider remainder reached divisor");
`endif

endmodule

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // a register index that maps to nothing, writes to it are dropped
   localparam logic [mcfe_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int PRINT_CAP = 40;

   // packed so that the last field, position, lands in the lowest bits of req_tdata
   typedef struct packed {
      logic signed [31:0] torque;
      logic signed [31:0] damping;
      logic signed [31:0] stiffness;
      logic signed [31:0] velocity;
      logic signed [31:0] position;
   } command_type;

   class frame_scoreboard;
      longint position_limit;
      longint velocity_bound;
      longint torque_limit;
      longint stiffness_lo;
      longint stiffness_hi;
      longint damping_lo;
      longint damping_hi;
      logic [mcfe_pkg::FRAME_W-1:0] expected_frames[$];
      int commands_seen;
      int frames_checked;
      int errors;

      function new();
         position_limit = longint'(mcfe_pkg::POSITION_LIMIT_RST);
         velocity_bound = longint'(mcfe_pkg::VELOCITY_BOUND_RST);
         torque_limit   = longint'(mcfe_pkg::TORQUE_LIMIT_RST);
         stiffness_lo   = longint'($signed(mcfe_pkg::STIFFNESS_MIN_RST));
         stiffness_hi   = longint'($signed(mcfe_pkg::STIFFNESS_MAX_RST));
         damping_lo     = longint'($signed(mcfe_pkg::DAMPING_MIN_RST));
         damping_hi     = longint'($signed(mcfe_pkg::DAMPING_MAX_RST));
         commands_seen  = 0;
         frames_checked = 0;
         errors         = 0;
      endfunction

      function void apply_register(logic [mcfe_pkg::CSR_IDX_W-1:0] index,
                                   logic [31:0] data);
         case (index)
            mcfe_pkg::CSR_POSITION_LIMIT: position_limit = longint'(data[30:0]);
            mcfe_pkg::CSR_VELOCITY_BOUND: velocity_bound = longint'(data[30:0]);
            mcfe_pkg::CSR_TORQUE_LIMIT:   torque_limit   = longint'(data[30:0]);
            mcfe_pkg::CSR_STIFFNESS_MIN:  stiffness_lo   = longint'($signed(data));
            mcfe_pkg::CSR_STIFFNESS_MAX:  stiffness_hi   = longint'($signed(data));
            mcfe_pkg::CSR_DAMPING_MIN:    damping_lo     = longint'($signed(data));
            mcfe_pkg::CSR_DAMPING_MAX:    damping_hi     = longint'($signed(data));
            default: ;
         endcase
      endfunction

      // round to nearest, ties upward, clamped to 0 .. 2^bits-1
      function longint scale_to_code(longint value, longint lo, longint hi, int bits);
         longint span;
         longint num;
         longint full;
         span = hi - lo;
         num  = value - lo;
         full = (longint'(1) << bits) - 1;
         if (span <= 0 || num <= 0)
            return 0;
         if (num >= span)
            return full;
         return (2 * num * full + span) / (2 * span);
      endfunction

      function logic [mcfe_pkg::FRAME_W-1:0] encode(command_type c);
         logic [15:0] p;
         logic [15:0] v;
         logic [15:0] kp;
         logic [15:0] kd;
         logic [15:0] t;
         p  = 16'(scale_to_code(longint'(c.position), -position_limit, position_limit,
                                mcfe_pkg::POS_BITS));
         v  = 16'(scale_to_code(longint'(c.velocity), -velocity_bound, velocity_bound,
                                mcfe_pkg::GAIN_BITS));
         kp = 16'(scale_to_code(longint'(c.stiffness), stiffness_lo, stiffness_hi,
                                mcfe_pkg::GAIN_BITS));
         kd = 16'(scale_to_code(longint'(c.damping), damping_lo, damping_hi,
                                mcfe_pkg::GAIN_BITS));
         t  = 16'(scale_to_code(longint'(c.torque), -torque_limit, torque_limit,
                                mcfe_pkg::GAIN_BITS));
         return {t[7:0], kd[3:0], t[11:8], kd[11:4], kp[7:0],
                 v[3:0], kp[11:8], v[11:4], p[7:0], p[15:8]};
      endfunction

      function void note_command(command_type c);
         expected_frames.push_back(encode(c));
         commands_seen++;
      endfunction

      function void check_frame(logic [mcfe_pkg::FRAME_W-1:0] got);
         logic [mcfe_pkg::FRAME_W-1:0] want;
         if (expected_frames.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: frame %h arrived with no command outstanding", $time, got);
            return;
         end
         want = expected_frames.pop_front();
         frames_checked++;
         for (int i = 0; i < 8; i++) begin
            if (got[8*i +: 8] !== want[8*i +: 8]) begin
               errors++;
               if (errors <= PRINT_CAP)
                  $display("%0t: frame %0d frame_byte_%0d expected %h actual %h",
                           $time, frames_checked, i, want[8*i +: 8], got[8*i +: 8]);
            end
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic [159:0]                   req_tdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [63:0]                    rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [mcfe_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                    csr_data = '0;

   frame_scoreboard model = new();
   int  range_settings = 1;
   int  input_stall_run = 0;
   int  longest_input_stall = 0;
   bit  sender_steady = 1'b0;

   always #5 clock = ~clock;

   mit_command_frame_encoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            model.check_frame(rsp_tdata);
         if (req_tvalid && !req_tready) begin
            input_stall_run++;
            if (input_stall_run > longest_input_stall)
               longest_input_stall = input_stall_run;
         end else begin
            input_stall_run = 0;
         end
      end
   end

   function automatic int pick_gap(bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly values inside [lo, hi] and at its edges, some anywhere
   function automatic logic signed [31:0] pick_value(longint lo, longint hi);
      longint          v;
      longint unsigned r64;
      int unsigned     mode;
      mode = $urandom_range(0, 9);
      r64  = {$urandom, $urandom};
      if (mode <= 1) begin
         v = longint'(int'($urandom));
      end else if (mode <= 6 && hi >= lo) begin
         v = lo + longint'(r64 % longint'(hi - lo + 1));
      end else if (mode <= 8) begin
         case ($urandom_range(0, 5))
            0: v = lo - 1;
            1: v = lo;
            2: v = lo + 1;
            3: v = hi - 1;
            4: v = hi;
            default: v = hi + 1;
         endcase
      end else begin
         v = longint'($urandom_range(0, 512)) - 256;
      end
      if (v > 64'sd2147483647)
         v = 64'sd2147483647;
      if (v < -64'sd2147483648)
         v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic command_type random_command();
      command_type c;
      c.position  = pick_value(-model.position_limit, model.position_limit);
      c.velocity  = pick_value(-model.velocity_bound, model.velocity_bound);
      c.stiffness = pick_value(model.stiffness_lo, model.stiffness_hi);
      c.damping   = pick_value(model.damping_lo, model.damping_hi);
      c.torque    = pick_value(-model.torque_limit, model.torque_limit);
      return c;
   endfunction

   function automatic command_type make_command(int p, int v, int kp, int kd, int t);
      command_type c;
      c.position  = p;
      c.velocity  = v;
      c.stiffness = kp;
      c.damping   = kd;
      c.torque    = t;
      return c;
   endfunction

   function automatic logic [31:0] pick_limit();
      logic [31:0] lim;
      case ($urandom_range(0, 5))
         0: lim = 32'd0;
         1: lim = 32'h7FFF_FFFF;
         2, 3: lim = $urandom_range(1, 4095);
         default: lim = $urandom;
      endcase
      // bit 31 is not stored, so scatter it
      lim[31] = 1'($urandom_range(0, 1));
      return lim;
   endfunction

   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom;
         default: return int'($urandom_range(0, 20000)) - 10000;
      endcase
   endfunction

   // holds a valid request until the block takes it
   task automatic send_command(command_type c);
      int gap;
      gap = pick_gap(sender_steady);
      if ($urandom_range(0, 39) == 0)
         sender_steady = !sender_steady;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      model.note_command(c);
   endtask

   task automatic send_random(int count);
      repeat (count) send_command(random_command());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (model.expected_frames.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high so back to back writes need one assignment per step
   task automatic write_register(logic [mcfe_pkg::CSR_IDX_W-1:0] index,
                                 logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      model.apply_register(index, data);
   endtask

   task automatic close_writes();
      csr_valid <= 1'b0;
      range_settings++;
   endtask

   task automatic write_gain_range(logic [mcfe_pkg::CSR_IDX_W-1:0] lo_index,
                                   logic [mcfe_pkg::CSR_IDX_W-1:0] hi_index);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] swap;
      a = pick_bound();
      b = pick_bound();
      // keep most ranges well ordered, leave some inverted
      if ($urandom_range(0, 4) != 0 && $signed(a) > $signed(b)) begin
         swap = a;
         a = b;
         b = swap;
      end
      write_register(lo_index, a);
      write_register(hi_index, b);
   endtask

   task automatic randomize_ranges();
      write_register(mcfe_pkg::CSR_POSITION_LIMIT, pick_limit());
      write_register(mcfe_pkg::CSR_VELOCITY_BOUND, pick_limit());
      write_register(mcfe_pkg::CSR_TORQUE_LIMIT, pick_limit());
      write_gain_range(mcfe_pkg::CSR_STIFFNESS_MIN, mcfe_pkg::CSR_STIFFNESS_MAX);
      write_gain_range(mcfe_pkg::CSR_DAMPING_MIN, mcfe_pkg::CSR_DAMPING_MAX);
      close_writes();
   endtask

   initial begin
      int stall;
      int next_hold;
      bit steady;
      next_hold = 150;
      steady    = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         // long hold-off so the pipeline fills and backs up into the request side
         if (model.frames_checked >= next_hold) begin
            stall = 250;
            next_hold += 450;
         end else begin
            stall = pick_gap(steady);
         end
         if ($urandom_range(0, 39) == 0)
            steady = !steady;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin
      #10ms;
      $display("%0t: timed out with %0d frames outstanding", $time,
               model.expected_frames.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset ranges: zero, rails, range ends and their neighbors
      send_command(make_command(0, 0, 0, 0, 0));
      send_command(make_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000));
      send_command(make_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_command(make_command(-819200, -1966080, 0, 0, -655360));
      send_command(make_command(-819199, -1966079, 1, 1, -655359));
      send_command(make_command(-819201, -1966081, -1, -1, -655361));
      send_command(make_command(819200, 1966080, 32768000, 327680, 655360));
      send_command(make_command(819199, 1966079, 32767999, 327679, 655359));
      send_command(make_command(819201, 1966081, 32768001, 327681, 655361));
      send_command(make_command(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                32'hAAAA_AAAA, 32'h5555_5555));
      send_command(make_command(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                32'h5555_5555, 32'hAAAA_AAAA));
      send_command(make_command(-1, 1, 16384000, 163840, -1));
      send_random(300);
      drain();

      // span of two: the midpoint is an exact tie and must round up
      write_register(mcfe_pkg::CSR_POSITION_LIMIT, 32'd1);
      write_register(mcfe_pkg::CSR_VELOCITY_BOUND, 32'd1);
      write_register(mcfe_pkg::CSR_TORQUE_LIMIT, 32'd1);
      write_register(mcfe_pkg::CSR_STIFFNESS_MIN, 32'd0);
      write_register(mcfe_pkg::CSR_STIFFNESS_MAX, 32'd2);
      write_register(mcfe_pkg::CSR_DAMPING_MIN, -32'sd1);
      write_register(mcfe_pkg::CSR_DAMPING_MAX, 32'd1);
      close_writes();
      send_command(make_command(-1, -1, 0, -1, -1));
      send_command(make_command(0, 0, 1, 0, 0));
      send_command(make_command(1, 1, 2, 1, 1));
      send_random(100);
      drain();

      // widest ranges, damping empty; position and velocity writes carry bit 31, which must be dropped
      write_register(mcfe_pkg::CSR_POSITION_LIMIT, 32'hFFFF_FFFF);
      write_register(mcfe_pkg::CSR_VELOCITY_BOUND, 32'hFFFF_FFFF);
      write_register(mcfe_pkg::CSR_TORQUE_LIMIT, 32'h7FFF_FFFF);
      write_register(mcfe_pkg::CSR_STIFFNESS_MIN, 32'h8000_0000);
      write_register(mcfe_pkg::CSR_STIFFNESS_MAX, 32'h7FFF_FFFF);
      write_register(mcfe_pkg::CSR_DAMPING_MIN, 32'd4096);
      write_register(mcfe_pkg::CSR_DAMPING_MAX, 32'd4096);
      write_register(CSR_UNMAPPED, 32'd12345);
      close_writes();
      send_command(make_command(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'd4096, 32'h8000_0001));
      send_command(make_command(32'h8000_0001, 0, 32'h7FFF_FFFF, 32'd4097, 0));
      send_random(200);
      drain();

      // empty and inverted ranges give code zero in every lane but damping, which keeps its widest range
      write_register(mcfe_pkg::CSR_POSITION_LIMIT, 32'h8000_0000);
      write_register(mcfe_pkg::CSR_VELOCITY_BOUND, 32'd0);
      write_register(mcfe_pkg::CSR_TORQUE_LIMIT, 32'd0);
      write_register(mcfe_pkg::CSR_STIFFNESS_MIN, 32'd100);
      write_register(mcfe_pkg::CSR_STIFFNESS_MAX, -32'sd100);
      write_register(mcfe_pkg::CSR_DAMPING_MIN, 32'h8000_0000);
      write_register(mcfe_pkg::CSR_DAMPING_MAX, 32'h7FFF_FFFF);
      close_writes();
      send_random(100);
      drain();

      repeat (6) begin
         randomize_ranges();
         send_random(100);
         drain();
      end

      repeat (mcfe_pkg::STAGES + 5) @(posedge clock);
      $display("covered %0d commands under %0d range settings, %0d frames compared",
               model.commands_seen, range_settings, model.frames_checked);
      $display("longest request backpressure %0d cycles, %0d byte mismatches",
               longest_input_stall, model.errors);
      if (model.errors == 0 && model.expected_frames.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
